### design/qpt_pkg.sv
// shared types, codes and the quadrature step table for the position tracker
package qpt_pkg;

  // operation codes carried by an input beat
  typedef enum logic [1:0] {
    OP_EDGE  = 2'd0,
    OP_INDEX = 2'd1,
    OP_PROBE = 2'd2
  } op_e;

  // tracking modes held in the track_mode register
  typedef enum logic [1:0] {
    MODE_QUAD       = 2'd0,
    MODE_QUAD_INDEX = 2'd1,
    MODE_SINGLE     = 2'd2,
    MODE_DISABLED   = 2'd3
  } mode_e;

  // configuration register indexes
  typedef enum logic {
    REG_TRACK_MODE     = 1'b0,
    REG_COUNTS_PER_REV = 1'b1
  } reg_idx_e;

  localparam int unsigned PosW  = 32;
  localparam int unsigned CprW  = 16;
  localparam int unsigned CfgDW = 16;

  localparam logic [1:0]      ModeReset = 2'd0;
  localparam logic [CprW-1:0] CprReset  = 16'd400;

  // step for {prev_b, prev_a, b, a}: 2'b11 is -1, 2'b01 is +1
  localparam logic [1:0] QuadStep [16] = '{
    2'b00, 2'b11, 2'b01, 2'b00,
    2'b01, 2'b00, 2'b00, 2'b11,
    2'b11, 2'b00, 2'b00, 2'b01,
    2'b00, 2'b01, 2'b11, 2'b00
  };

  // tracker state carried between events
  typedef struct packed {
    logic [1:0]      prev_ab;
    logic [PosW-1:0] pos;
    logic [1:0]      last_step;
    logic [PosW-1:0] ticks;
    logic [2:0]      mask;
  } track_state_t;

endpackage

### design/qpt_update.sv
// next-state logic for one encoder event
module qpt_update (
  input  qpt_pkg::track_state_t      st_i,
  input  logic [1:0]                 op_i,
  input  logic                       chan_a_i,
  input  logic                       chan_b_i,
  input  logic                       chan_z_i,
  input  logic [1:0]                 mode_i,
  input  logic [qpt_pkg::CprW-1:0]   cpr_i,
  output qpt_pkg::track_state_t      st_o
);

  logic [1:0]               cur_ab;
  logic [3:0]               tbl_idx;
  logic [1:0]               step;
  logic [qpt_pkg::PosW-1:0] sum;
  logic [qpt_pkg::PosW-1:0] inc;
  logic [qpt_pkg::PosW-1:0] cpr_ext;
  logic                     sum_above;
  logic                     inc_above;

  // table lookup and candidate positions
  assign cur_ab    = {chan_b_i, chan_a_i};
  assign tbl_idx   = {st_i.prev_ab, cur_ab};
  assign step      = qpt_pkg::QuadStep[tbl_idx];
  assign sum       = st_i.pos + {{(qpt_pkg::PosW-2){step[1]}}, step};
  assign inc       = st_i.pos + {{(qpt_pkg::PosW-1){1'b0}}, 1'b1};
  assign cpr_ext   = {{(qpt_pkg::PosW-qpt_pkg::CprW){1'b0}}, cpr_i};
  assign sum_above = $signed(sum) > $signed(cpr_ext);
  assign inc_above = $signed(inc) > $signed(cpr_ext);

  // apply the event
  always_comb begin
    st_o = st_i;
    unique case (qpt_pkg::op_e'(op_i))
      qpt_pkg::OP_EDGE: begin
        unique case (qpt_pkg::mode_e'(mode_i))
          qpt_pkg::MODE_QUAD: begin
            st_o.prev_ab   = cur_ab;
            st_o.last_step = step;
            priority if (sum == '0) begin
              st_o.pos = cpr_ext;
            end else if (sum_above) begin
              st_o.pos = {{(qpt_pkg::PosW-1){1'b0}}, 1'b1};
            end else begin
              st_o.pos = sum;
            end
            st_o.ticks = st_i.ticks + {{(qpt_pkg::PosW-1){1'b0}}, 1'b1};
          end
          qpt_pkg::MODE_QUAD_INDEX: begin
            st_o.prev_ab   = cur_ab;
            st_o.last_step = step;
            st_o.pos       = sum;
          end
          qpt_pkg::MODE_SINGLE: begin
            st_o.pos = inc_above ? {{(qpt_pkg::PosW-1){1'b0}}, 1'b1} : inc;
          end
          qpt_pkg::MODE_DISABLED: begin
            st_o = st_i;
          end
          default: begin
            st_o = st_i;
          end
        endcase
      end
      qpt_pkg::OP_INDEX: begin
        st_o.pos   = {{(qpt_pkg::PosW-1){1'b0}}, 1'b1};
        st_o.ticks = st_i.ticks + {{(qpt_pkg::PosW-1){1'b0}}, 1'b1};
      end
      qpt_pkg::OP_PROBE: begin
        st_o.mask = st_i.mask | {chan_z_i, chan_b_i, chan_a_i};
      end
      default: begin
        st_o = st_i;
      end
    endcase
  end

endmodule

### design/quadrature_position_tracker.sv
// quadrature position tracker top level: input register, event update, result register
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid_i, in_stall_o, op/chan_a/b/z_i   | sink
//   out     | out_valid_o, out_stall_i, position/step/  | source
//           | event_count/channel_mask_o                |
//   cfg     | cfg_we_i, cfg_idx_i, cfg_data_i           | write only
//
// one beat per cycle sustained while out is not stalled; an accepted beat goes
// through the input register, then the update logic into the result register
// reset clears the tracker state and loads mode 0 and 400 counts per revolution
// a stalled output holds its beat while one more input beat waits in the input
// register; in_stall_o rises only when both registers are full and out is stalled
module quadrature_position_tracker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       op_i,
  input  logic                             chan_a_i,
  input  logic                             chan_b_i,
  input  logic                             chan_z_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [qpt_pkg::PosW-1:0]  position_o,
  output logic signed [1:0]                step_o,
  output logic [qpt_pkg::PosW-1:0]         event_count_o,
  output logic [2:0]                       channel_mask_o,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [qpt_pkg::CfgDW-1:0]        cfg_data_i
);

  logic                       s1_valid_q;
  logic [1:0]                 s1_op_q;
  logic                       s1_a_q;
  logic                       s1_b_q;
  logic                       s1_z_q;
  logic                       out_valid_q;
  logic                       in_take;
  logic                       s1_go;
  logic [1:0]                 mode_q;
  logic [qpt_pkg::CprW-1:0]   cpr_q;
  qpt_pkg::track_state_t      state_q;
  qpt_pkg::track_state_t      state_d;

  // handshake: the stage advances when the result register is free or draining
  assign s1_go      = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_take    = in_valid_i && !in_stall_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= qpt_pkg::ModeReset;
      cpr_q  <= qpt_pkg::CprReset;
    end else if (cfg_we_i) begin
      unique case (qpt_pkg::reg_idx_e'(cfg_idx_i))
        qpt_pkg::REG_TRACK_MODE:     mode_q <= cfg_data_i[1:0];
        qpt_pkg::REG_COUNTS_PER_REV: cpr_q  <= cfg_data_i[qpt_pkg::CprW-1:0];
        default: ;
      endcase
    end
  end

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_op_q <= op_i;
      s1_a_q  <= chan_a_i;
      s1_b_q  <= chan_b_i;
      s1_z_q  <= chan_z_i;
    end
  end

  // event update
  qpt_update u_update (
    .st_i     (state_q),
    .op_i     (s1_op_q),
    .chan_a_i (s1_a_q),
    .chan_b_i (s1_b_q),
    .chan_z_i (s1_z_q),
    .mode_i   (mode_q),
    .cpr_i    (cpr_q),
    .st_o     (state_d)
  );

  // tracker state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (s1_go) begin
      state_q <= state_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      position_o     <= state_d.pos;
      step_o         <= state_d.last_step;
      event_count_o  <= state_d.ticks;
      channel_mask_o <= state_d.mask;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
